/* hw/rtl/sgm_pkg.sv */
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared types and constants of the Sobel gradient magnitude block.
// ----------------------------------------------------------------------------
package sgm_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int HEIGHT_LIMIT  = 1024;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W     = 8;
  localparam int MAG_W     = 11;
  localparam int MAG_MAX   = 1443;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // luma weights scaled by 10000, divide by 10000 via reciprocal
  localparam int W_RED   = 2125;
  localparam int W_GREEN = 7154;
  localparam int W_BLUE  = 721;
  localparam int SUM_W   = 22;
  localparam int RECIP_W = 23;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(6871948);
  localparam int RECIP_SHIFT = 36;

  localparam int TAP_W      = PIX_W + 2;
  localparam int GRAD_W     = 11;
  localparam int SQ_W       = 21;
  localparam int ROOT_W     = 22;
  localparam int ROOT_STEPS = 11;
  localparam int ITER_W     = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_GRAD,
    ST_SQUARE,
    ST_ROOT,
    ST_HOLD
  } sgm_state_t;

  function automatic logic [TAP_W-1:0] tap_sum(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b,
                                               input logic [PIX_W-1:0] c);
    return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
  endfunction

endpackage

/* hw/rtl/sobel_gradient_magnitude.sv */
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude
// RGB to grey, 3x3 Sobel window over two line buffers, gradient magnitude.
// ----------------------------------------------------------------------------
// Item producing a result: no new item is taken until its result is loaded;
// steps are line-buffer read, grey divide, gradient, square, 11-step square
// root. Item without result: ends after gradient. Ignored flush: stays idle.
// Synchronous active-low reset: position and window cleared, registers to
// 640x480; line buffers are not cleared.
module sobel_gradient_magnitude
  import sgm_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_opcode,
  input  logic [PIX_W-1:0]     in_red,
  input  logic [PIX_W-1:0]     in_green,
  input  logic [PIX_W-1:0]     in_blue,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [MAG_W-1:0]     out_magnitude,
  output logic                 out_end_of_frame,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int LW = 2 * PIX_W;

  sgm_state_t state_r, state_nxt;

  logic [CFG_W-1:0]  width_r, width_nxt;
  logic [CFG_W-1:0]  height_r, height_nxt;
  logic [AW-1:0]     x_r, x_nxt;
  logic [CFG_W-1:0]  y_r, y_nxt;
  logic [PIX_W-1:0]  win_r [6];
  logic [PIX_W-1:0]  win_nxt [6];
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [PIX_W-1:0]  grey_r, grey_nxt;
  logic [PIX_W-1:0]  top_r, top_nxt;
  logic [PIX_W-1:0]  mid_r, mid_nxt;
  logic [PIX_W-1:0]  midraw_r, midraw_nxt;
  logic              eof_r, eof_nxt;
  logic signed [GRAD_W-1:0] gx_r, gx_nxt;
  logic signed [GRAD_W-1:0] gy_r, gy_nxt;
  logic [SQ_W-1:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0] res_r, res_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [MAG_W-1:0]  out_mag_r, out_mag_nxt;
  logic              out_eof_r, out_eof_nxt;

  logic [CFG_W-1:0]  w_eff, h_eff;
  logic              y_ge1, y_ge2, y_lt_h, y_last, x_zero, pos_wrap;
  logic              accept, ignore, pixel, emit, out_free, out_load, mem_we;
  logic              root_done;
  logic [LW-1:0]     mem_rdata;
  logic [SUM_W+RECIP_W-1:0] prod;
  logic [PIX_W-1:0]  col [3];
  logic [PIX_W-1:0]  rgt [3];
  logic [TAP_W-1:0]  sum_l, sum_r3, sum_t, sum_b;
  logic signed [2*GRAD_W-1:0] gx2, gy2;
  logic [2*GRAD_W-1:0] sq_full;
  logic [4:0]        shamt;
  logic [ROOT_W-1:0] bitv, trial;

  sgm_ram #(
    .WIDTH(LW),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (mem_we),
    .addr (x_r),
    .wdata({midraw_r, grey_r}),
    .rdata(mem_rdata)
  );

  // effective frame size and position tests
  always_comb begin
    if (width_r == '0) begin
      w_eff = CFG_W'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      w_eff = CFG_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = CFG_W'(1);
    end else if (int'(height_r) > HEIGHT_LIMIT) begin
      h_eff = CFG_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = height_r;
    end
    y_ge1    = (y_r != '0);
    y_ge2    = (y_r >= CFG_W'(2));
    y_lt_h   = (y_r < h_eff);
    y_last   = ({1'b0, y_r} >= ({1'b0, h_eff} + (CFG_W+1)'(1)));
    x_zero   = (x_r == '0);
    pos_wrap = ((int'(x_r) + 1) >= int'(w_eff));
    emit     = x_zero ? y_ge2 : y_ge1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept && !ignore) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_GRAD;
      ST_GRAD:   state_nxt = emit ? ST_SQUARE : ST_IDLE;
      ST_SQUARE: state_nxt = ST_ROOT;
      ST_ROOT:   if (root_done) state_nxt = ST_HOLD;
      ST_HOLD:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_GRAD: mem_we   = 1'b1;
      ST_HOLD: out_load = out_free;
      default: ;
    endcase
  end

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign ignore    = (in_opcode == OP_FLUSH) && y_lt_h;
  assign pixel     = (in_opcode == OP_PIXEL) && y_lt_h;
  assign out_free  = !out_valid_r || out_ready;
  assign root_done = (iter_r == ITER_W'(ROOT_STEPS - 1));

  assign prod = {{RECIP_W{1'b0}}, sum_r} * {{SUM_W{1'b0}}, RECIP};

  // datapath
  always_comb begin
    width_nxt     = width_r;
    height_nxt    = height_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    win_nxt       = win_r;
    sum_nxt       = sum_r;
    grey_nxt      = grey_r;
    top_nxt       = top_r;
    mid_nxt       = mid_r;
    midraw_nxt    = midraw_r;
    eof_nxt       = eof_r;
    gx_nxt        = gx_r;
    gy_nxt        = gy_r;
    rem_nxt       = rem_r;
    res_nxt       = res_r;
    iter_nxt      = iter_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_mag_nxt   = out_mag_r;
    out_eof_nxt   = out_eof_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  width_nxt  = cfg_data;
        CFG_FRAME_HEIGHT: height_nxt = cfg_data;
        default: ;
      endcase
    end

    col[0] = top_r;
    col[1] = mid_r;
    col[2] = grey_r;
    for (int i = 0; i < 3; i++) begin
      rgt[i] = x_zero ? '0 : col[i];
    end
    sum_l  = tap_sum(win_r[0], win_r[1], win_r[2]);
    sum_r3 = tap_sum(rgt[0], rgt[1], rgt[2]);
    sum_t  = tap_sum(win_r[0], win_r[3], rgt[0]);
    sum_b  = tap_sum(win_r[2], win_r[5], rgt[2]);

    gx2     = gx_r * gx_r;
    gy2     = gy_r * gy_r;
    sq_full = unsigned'(gx2) + unsigned'(gy2);

    shamt = 5'(2 * (ROOT_STEPS - 1 - int'(iter_r)));
    bitv  = ROOT_W'(1) << shamt;
    trial = res_r + bitv;

    if (accept && !ignore) begin
      sum_nxt = pixel ? SUM_W'(W_RED * int'(in_red) + W_GREEN * int'(in_green)
                               + W_BLUE * int'(in_blue)) : '0;
    end

    case (state_r)
      ST_READ: begin
        grey_nxt   = prod[RECIP_SHIFT +: PIX_W];
        top_nxt    = y_ge2 ? mem_rdata[LW-1:PIX_W] : '0;
        mid_nxt    = y_ge1 ? mem_rdata[PIX_W-1:0] : '0;
        midraw_nxt = mem_rdata[PIX_W-1:0];
      end
      ST_GRAD: begin
        gx_nxt  = $signed({1'b0, sum_r3}) - $signed({1'b0, sum_l});
        gy_nxt  = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
        eof_nxt = x_zero && y_last;
        if (x_zero && y_last) begin
          for (int i = 0; i < 6; i++) win_nxt[i] = '0;
          x_nxt = '0;
          y_nxt = '0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            win_nxt[i]     = x_zero ? '0 : win_r[i+3];
            win_nxt[i + 3] = col[i];
          end
          if (pos_wrap) begin
            x_nxt = '0;
            y_nxt = y_r + CFG_W'(1);
          end else begin
            x_nxt = x_r + AW'(1);
          end
        end
      end
      ST_SQUARE: begin
        rem_nxt  = sq_full[SQ_W-1:0];
        res_nxt  = '0;
        iter_nxt = '0;
      end
      ST_ROOT: begin
        if ({1'b0, rem_r} >= trial) begin
          rem_nxt = rem_r - trial[SQ_W-1:0];
          res_nxt = (res_r >> 1) + bitv;
        end else begin
          res_nxt = res_r >> 1;
        end
        iter_nxt = iter_r + ITER_W'(1);
      end
      default: ;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_mag_nxt   = res_r[MAG_W-1:0];
      out_eof_nxt   = eof_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      width_r     <= FRAME_WIDTH_RST;
      height_r    <= FRAME_HEIGHT_RST;
      x_r         <= '0;
      y_r         <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      out_valid_r <= out_valid_nxt;
      win_r       <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r     <= sum_nxt;
    grey_r    <= grey_nxt;
    top_r     <= top_nxt;
    mid_r     <= mid_nxt;
    midraw_r  <= midraw_nxt;
    eof_r     <= eof_nxt;
    gx_r      <= gx_nxt;
    gy_r      <= gy_nxt;
    rem_r     <= rem_nxt;
    res_r     <= res_nxt;
    iter_r    <= iter_nxt;
    out_mag_r <= out_mag_nxt;
    out_eof_r <= out_eof_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_magnitude    = out_mag_r;
  assign out_end_of_frame = out_eof_r;

endmodule

/* hw/rtl/sgm_ram.sv */
// ----------------------------------------------------------------------------
// sgm_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module sgm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                        wdata,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hw/rtl/sgm_checker.sv */
// ----------------------------------------------------------------------------
// sgm_checker
// Port-level checks of the Sobel gradient magnitude block, bound to the top.
// ----------------------------------------------------------------------------
module sgm_checker
  import sgm_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_opcode,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [MAG_W-1:0]     out_magnitude,
  input logic                 out_end_of_frame
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_magnitude)
                                && $stable(out_end_of_frame))
    else $error("stalled result item changed");

  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_magnitude <= MAG_W'(MAG_MAX))
    else $error("magnitude out of range");

  a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == OP_PIXEL |=> !in_ready)
    else $error("pixel item not processed");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result item appeared while idle");

endmodule

bind sobel_gradient_magnitude sgm_checker u_sgm_checker (.*);
